// File: rtl/core/ecg_autoscale_chart_mapper_assert.svh
// Assertion macros for the chart mapper
`ifndef ECG_AUTOSCALE_CHART_MAPPER_ASSERT_SVH
`define ECG_AUTOSCALE_CHART_MAPPER_ASSERT_SVH
`ifndef SYNTH
`define ECA_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ECA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ECA_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define ECA_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// File: rtl/core/eca_pkg.sv
package eca_pkg;
    localparam int SAMPLE_WIDTH_DEF  = 20;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int REG_WIDTH         = 10;
    localparam int CFG_IDX_WIDTH     = 3;
    localparam int LEVEL_WIDTH       = 8;
    localparam int COEF_SHIFT        = 16;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ENV_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ENV_CEIL    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TGT_FLOOR   = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SCALE_FLOOR = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SCALE_CEIL  = 3'd4;

    localparam logic [16:0] K_BASE   = 17'd524;
    localparam logic [16:0] K_ATTACK = 17'd13107;
    localparam logic [16:0] K_DECAY  = 17'd328;
    localparam logic [16:0] K_SCALE  = 17'd1966;
    localparam logic [16:0] K_GAIN   = 17'd124518;
    localparam logic [16:0] K_LIMIT  = 17'd62259;

    typedef enum logic [3:0] {
        t_IDLE_S, t_BASE_S, t_ENV_S, t_ENVC_S, t_TGT_S, t_SCL_S, t_LIM_S,
        t_DIV_S, t_DONE_S, t_OUT_S
    } t_state;

    typedef struct packed {
        logic start;
        logic neg;
    } t_mul_ctl;
endpackage

// File: rtl/core/eca_serial_mul.sv
module eca_serial_mul #(
    parameter int AW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  eca_pkg::t_mul_ctl i_ctl,
    input  logic [AW-1:0] i_mag,
    input  logic [16:0]   i_coef,
    output logic          o_done,
    output logic signed [AW:0] o_res
);
    import eca_pkg::*;
    localparam int PW = AW + 17;
    localparam int CW = 5;

    logic [PW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_a;
    logic [16:0]   r_k;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_neg, r_done;
    logic [PW-1:0] w_rnd;
    logic [AW-1:0] w_mag;

    // add one partial product per coefficient bit
    always_comb begin
        n_acc = r_acc;
        if (r_k[0]) n_acc = r_acc + ({{17{1'b0}}, r_a} << r_cnt);
    end

    assign w_rnd = r_acc + PW'(32768);
    assign w_mag = w_rnd[COEF_SHIFT +: AW];
    assign o_res = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= i_mag;
                r_k    <= i_coef;
                r_neg  <= i_ctl.neg;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_k   <= r_k >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(16)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: rtl/core/ecg_autoscale_chart_mapper.sv
// One sample in flight: the input is stalled from acceptance until the result is handed over,
// plus any stall on the result. With leads on, five serial multiplies, an envelope clamping
// state, a restoring divide for the 8-bit quotient, then a finish state and a hand-over state
// make up the work; with leads off the sample goes straight to the hand-over state.
// Reset (synchronous, active low) restores register defaults, baseline 0,
// envelope 130 mV, scale 230 mV and arms the re-prime.
module ecg_autoscale_chart_mapper #(
    parameter int SAMPLE_WIDTH  = eca_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = eca_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_value,
    input  logic                          i_leads_on,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [eca_pkg::LEVEL_WIDTH-1:0] o_chart_level,
    output logic                          o_signal_ok,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [eca_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [eca_pkg::REG_WIDTH-1:0] i_cfg_data
);
    import eca_pkg::*;
    `include "ecg_autoscale_chart_mapper_assert.svh"
    localparam int US = 4 + FRACTION_BITS;
    localparam int W  = SAMPLE_WIDTH + FRACTION_BITS + 3;
    localparam int AW = W;

    logic [REG_WIDTH-1:0] r_env_fl, r_env_cl, r_tgt_fl, r_scl_fl, r_scl_cl;
    logic signed [W-1:0] r_base, r_env, r_scl, r_x, r_cen, r_tgt, r_lim;
    logic r_prime;
    t_state r_st, n_st;
    logic r_ovalid;
    logic [LEVEL_WIDTH-1:0] r_level;
    logic r_ok;

    function automatic logic signed [W-1:0] mv(input logic [REG_WIDTH-1:0] v);
        mv = $signed(W'({v, {US{1'b0}}}));
    endfunction

    // multiplier operands
    t_mul_ctl w_mctl;
    logic signed [W-1:0] w_mop;
    logic [16:0] w_k;
    logic [AW-1:0] w_mmag;
    logic w_mdone;
    logic signed [AW:0] w_mres;
    logic signed [W-1:0] w_mr;
    logic r_mgo;

    assign w_mmag = w_mop[W-1] ? AW'(-w_mop) : AW'(w_mop);
    assign w_mctl.start = r_mgo;
    assign w_mctl.neg = w_mop[W-1];
    assign w_mr = W'(w_mres);

    eca_serial_mul #(.AW(AW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_mctl), .i_mag(w_mmag),
        .i_coef(w_k), .o_done(w_mdone), .o_res(w_mres)
    );

    logic signed [W-1:0] w_xc, w_mag;
    assign w_xc = (r_x < mv(10'd150) && r_x > -mv(10'd150)) ? r_x :
                  (r_x[W-1] ? -mv(10'd150) : mv(10'd150));
    assign w_mag = r_cen[W-1] ? -r_cen : r_cen;

    always_comb begin
        w_mop = '0;
        w_k = K_BASE;
        case (r_st)
            t_BASE_S: begin w_mop = w_xc - r_base; w_k = K_BASE; end
            t_ENV_S:  begin
                w_mop = w_mag - r_env;
                w_k = (w_mag > r_env) ? K_ATTACK : K_DECAY;
            end
            t_TGT_S:  begin w_mop = r_env; w_k = K_GAIN; end
            t_SCL_S:  begin w_mop = r_tgt - r_scl; w_k = K_SCALE; end
            t_LIM_S:  begin w_mop = r_scl; w_k = K_LIMIT; end
            default:  begin w_mop = '0; w_k = K_BASE; end
        endcase
    end

    // divider: quotient bits of (|c|*100)/scale, one per cycle
    localparam int QW = 8;
    logic [W+7:0] r_rem;
    logic [QW-1:0] r_q;
    logic [3:0] r_dcnt;
    logic r_dneg, r_dnz;
    logic [W+7:0] w_try;
    assign w_try = r_rem - ({8'd0, r_scl} << (QW - 1 - r_dcnt));

    // negative results round the magnitude up
    logic [QW-1:0] w_qfin;
    assign w_qfin = r_q + {{(QW-1){1'b0}}, (r_dneg && r_rem != '0)};

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_IDLE_S: if (i_valid) n_st = i_leads_on ? t_BASE_S : t_OUT_S;
            t_BASE_S, t_ENV_S, t_TGT_S, t_SCL_S, t_LIM_S:
                if (w_mdone) n_st = t_state'(r_st + 4'd1);
            t_ENVC_S: n_st = t_TGT_S;
            t_DIV_S:  if (r_dcnt == 4'(QW - 1)) n_st = t_DONE_S;
            t_DONE_S: n_st = t_OUT_S;
            t_OUT_S:  if (!r_ovalid || !i_stall) n_st = t_IDLE_S;
            default:  n_st = t_IDLE_S;
        endcase
    end

    always_comb begin
        o_stall = (r_st != t_IDLE_S);
        o_cfg_ready = (r_st == t_IDLE_S) && !r_ovalid;
    end

    logic signed [W-1:0] w_ecl, w_lc, w_absl;
    always_comb begin
        w_ecl = r_env;
        if (w_ecl < mv(r_env_fl)) w_ecl = mv(r_env_fl);
        if (w_ecl > mv(r_env_cl)) w_ecl = mv(r_env_cl);
        w_lc = r_cen;
        if (w_lc < -r_lim) w_lc = -r_lim;
        if (w_lc > r_lim) w_lc = r_lim;
        w_absl = w_lc[W-1] ? -w_lc : w_lc;
    end

    logic signed [W-1:0] w_s1;
    always_comb begin
        w_s1 = r_scl + w_mr;
        if (w_s1 < mv(r_scl_fl)) w_s1 = mv(r_scl_fl);
        if (w_s1 > mv(r_scl_cl)) w_s1 = mv(r_scl_cl);
    end

    logic signed [W-1:0] w_xin;
    assign w_xin = W'(i_sample_value) <<< FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_IDLE_S;
            r_env_fl <= 10'd95; r_env_cl <= 10'd320; r_tgt_fl <= 10'd230;
            r_scl_fl <= 10'd210; r_scl_cl <= 10'd430;
            r_base <= '0; r_env <= mv(10'd130); r_scl <= mv(10'd230);
            r_prime <= 1'b1; r_ovalid <= 1'b0; r_mgo <= 1'b0;
        end else begin
            r_st <= n_st;
            r_mgo <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ENV_FLOOR:   r_env_fl <= i_cfg_data;
                    REG_ENV_CEIL:    r_env_cl <= i_cfg_data;
                    REG_TGT_FLOOR:   r_tgt_fl <= i_cfg_data;
                    REG_SCALE_FLOOR: r_scl_fl <= i_cfg_data;
                    REG_SCALE_CEIL:  r_scl_cl <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                t_IDLE_S: if (i_valid) begin
                    r_ok <= i_leads_on;
                    r_level <= 8'd50;
                    if (!i_leads_on) r_prime <= 1'b1;
                    else begin
                        r_x <= w_xin;
                        r_mgo <= 1'b1;
                        if (r_prime) begin
                            r_base <= w_xin; r_env <= mv(10'd130);
                            r_scl <= mv(10'd230); r_prime <= 1'b0;
                        end
                    end
                end
                t_BASE_S: if (w_mdone) begin
                    r_base <= r_base + w_mr;
                    r_cen <= r_x - (r_base + w_mr);
                    r_mgo <= 1'b1;
                end
                t_ENV_S: if (w_mdone) r_env <= r_env + w_mr;
                t_ENVC_S: begin r_env <= w_ecl; r_mgo <= 1'b1; end
                t_TGT_S: if (w_mdone) begin
                    r_tgt <= (w_mr < mv(r_tgt_fl)) ? mv(r_tgt_fl) : w_mr;
                    r_mgo <= 1'b1;
                end
                t_SCL_S: if (w_mdone) begin r_scl <= w_s1; r_mgo <= 1'b1; end
                t_LIM_S: if (w_mdone) r_lim <= w_mr;
                default: ;
            endcase
            if (r_st == t_LIM_S && w_mdone) begin
                r_dcnt <= '0;
                r_dnz <= (r_scl > 0);
            end
            if (r_st == t_DIV_S) begin
                if (r_dcnt == 4'd0) begin
                    r_dneg <= w_lc[W-1];
                end
                r_dcnt <= r_dcnt + 4'd1;
            end
            if (r_st == t_DONE_S) begin
                if (!r_dnz) r_level <= 8'd100;
                else if (r_dneg) r_level <= (w_qfin > 8'd100) ? 8'd0 : 8'd100 - w_qfin;
                else r_level <= (w_qfin > 8'd100) ? 8'd200 : 8'd100 + w_qfin;
            end
            if (r_st == t_OUT_S && n_st == t_IDLE_S) begin
                r_ovalid <= 1'b1;
                o_chart_level <= r_level;
                o_signal_ok <= r_ok;
            end
        end
    end

    // divide: load remainder on entry, then restore per bit, shifting the quotient in
    always_ff @(posedge i_clk) begin
        if (r_st == t_LIM_S && w_mdone) begin
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_st == t_DIV_S) begin
            if (r_dcnt == 4'd0) begin
                if ((W + 8)'(w_absl) * 7'd100 >= ({8'd0, r_scl} << (QW - 1))) begin
                    r_rem <= (W + 8)'(w_absl) * 7'd100 - ({8'd0, r_scl} << (QW - 1));
                    r_q <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= (W + 8)'(w_absl) * 7'd100;
                    r_q <= {r_q[QW-2:0], 1'b0};
                end
            end else if (!w_try[W+7]) begin
                r_rem <= w_try;
                r_q <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_ovalid;

    `ECA_ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_st != t_IDLE_S, o_stall, "busy but not stalling")
    `ECA_ASSERT_IMPL(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, r_st == t_IDLE_S, "cfg while busy")
    `ECA_ASSERT_NEXT(a_off_level, i_clk, i_rst_n, r_st == t_IDLE_S && i_valid && !i_leads_on, r_level == 8'd50, "leads off level")
endmodule
